// ----- src/euler_to_quaternion_macros.svh -----
// Assertion macros for the Euler-to-quaternion converter
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Check that a condition implies a consequence in the next cycle
`define E2Q_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

// Check that a condition holds at every clock edge
`define E2Q_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ----- src/e2q_pkg.sv -----
package e2q_pkg;

    // CORDIC depth and fixed-point constants, Q30 radians
    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [CW-1:0] PI_HALF_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sh26DD3B6A;

    // Per-angle sine/cosine in Q30
    typedef struct packed {
        logic signed [CW-1:0] sn;
        logic signed [CW-1:0] cs;
    } sincos_t;

    // Truncated Q30 arctangent table
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

// ----- src/e2q_cordic_lane.sv -----
// Pipelined half-angle sine/cosine: range reduction, then one CORDIC step per stage
module e2q_cordic_lane
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output sincos_t                       result
);

    localparam int NS = CORDIC_STEPS;

    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [CW-1:0] h_reg [NS+1];
    logic                 f_reg [NS+1];
    logic signed [CW-1:0] h_in;
    logic signed [CW-1:0] h_red;
    logic                 f_red;

    // Halve the angle into Q30 and fold it into +-pi/2
    always_comb
    begin
        h_in = CW'(angle) <<< (33 - ANGLE_WIDTH);
        h_red = h_in;
        f_red = 1'b0;
        if (h_in > PI_HALF_Q30)
        begin
            h_red = h_in - PI_Q30;
            f_red = 1'b1;
        end
        else if (h_in < -PI_HALF_Q30)
        begin
            h_red = h_in + PI_Q30;
            f_red = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_GAIN_Q30;
        y_reg[0] <= '0;
        h_reg[0] <= h_red;
        f_reg[0] <= f_red;
    end

    // Advance one rotation per stage
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (!h_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                h_reg[i+1] <= h_reg[i] - atan_q30(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                h_reg[i+1] <= h_reg[i] + atan_q30(5'(i));
            end
            f_reg[i+1] <= f_reg[i];
        end
    end

    // Negate on fold
    assign result.sn = f_reg[NS] ? -y_reg[NS] : y_reg[NS];
    assign result.cs = f_reg[NS] ? -x_reg[NS] : x_reg[NS];

endmodule

// ----- src/e2q_merge.sv -----
// Combine the three lanes into quaternion components: products, sums, rounding, saturation
module e2q_merge
    import e2q_pkg::*;
#(
    parameter int QUAT_WIDTH = 16
)
(
    input  logic                         clk,
    input  sincos_t                      roll,
    input  sincos_t                      pitch,
    input  sincos_t                      yaw,
    output logic signed [QUAT_WIDTH-1:0] quat_x,
    output logic signed [QUAT_WIDTH-1:0] quat_y,
    output logic signed [QUAT_WIDTH-1:0] quat_z,
    output logic signed [QUAT_WIDTH-1:0] quat_w
);

    localparam int PW = 2 * CW;
    localparam int SH = 31 - QUAT_WIDTH;
    localparam logic signed [CW+1:0] HI = (CW+2)'((64'sd1 <<< (QUAT_WIDTH - 1)) - 1);
    localparam logic signed [CW+1:0] LO = -HI - 1;

    // Round half up, Q60 to Q30
    function automatic logic signed [CW-1:0] mq(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
        return CW'(p >>> 30);
    endfunction

    function automatic logic signed [QUAT_WIDTH-1:0] qout(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] t;
        if (SH > 0)
            t = (v + ((CW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> (SH > 0 ? SH : 0);
        else if (SH < 0)
            t = v <<< 1;
        else
            t = v;
        if (t > HI)
            t = HI;
        if (t < LO)
            t = LO;
        return QUAT_WIDTH'(t);
    endfunction

    // Stage 1: pairwise roll x pitch products
    logic signed [CW-1:0] srcp_reg, crsp_reg, crcp_reg, srsp_reg;
    logic signed [CW-1:0] sy_reg, cy_reg;
    always_ff @(posedge clk)
    begin
        srcp_reg <= mq(roll.sn, pitch.cs);
        crsp_reg <= mq(roll.cs, pitch.sn);
        crcp_reg <= mq(roll.cs, pitch.cs);
        srsp_reg <= mq(roll.sn, pitch.sn);
        sy_reg <= yaw.sn;
        cy_reg <= yaw.cs;
    end

    // Stage 2: multiply by yaw terms
    logic signed [CW-1:0] t_reg [8];
    always_ff @(posedge clk)
    begin
        t_reg[0] <= mq(srcp_reg, cy_reg);
        t_reg[1] <= mq(crsp_reg, sy_reg);
        t_reg[2] <= mq(crsp_reg, cy_reg);
        t_reg[3] <= mq(srcp_reg, sy_reg);
        t_reg[4] <= mq(crcp_reg, sy_reg);
        t_reg[5] <= mq(srsp_reg, cy_reg);
        t_reg[6] <= mq(crcp_reg, cy_reg);
        t_reg[7] <= mq(srsp_reg, sy_reg);
    end

    // Stage 3: sum, scale, saturate
    always_ff @(posedge clk)
    begin
        quat_x <= qout((CW+2)'(t_reg[0]) - (CW+2)'(t_reg[1]));
        quat_y <= qout((CW+2)'(t_reg[2]) + (CW+2)'(t_reg[3]));
        quat_z <= qout((CW+2)'(t_reg[4]) - (CW+2)'(t_reg[5]));
        quat_w <= qout((CW+2)'(t_reg[6]) + (CW+2)'(t_reg[7]));
    end

endmodule

// ----- src/euler_to_quaternion.sv -----
// Channel   | Ports                                    | Handshake
// request   | roll_angle, pitch_angle, yaw_angle       | start & !busy
// result    | quat_x, quat_y, quat_z, quat_w           | done, one cycle
//
// A request is taken every cycle; busy is always low.
// The valid pipeline matches the data path: 31 CORDIC stages in each lane, 3 in the merge stage.
// Reset clears only the valid pipeline; payload registers are not reset.
// Results cannot be stalled; done marks each one for exactly one cycle.
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int QUAT_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
    input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                          done,
    output logic signed [QUAT_WIDTH-1:0]  quat_x,
    output logic signed [QUAT_WIDTH-1:0]  quat_y,
    output logic signed [QUAT_WIDTH-1:0]  quat_z,
    output logic signed [QUAT_WIDTH-1:0]  quat_w
);

    localparam int LAT = CORDIC_STEPS + 4;

    sincos_t sc_roll, sc_pitch, sc_yaw;

    e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll
    (
        .clk(clk), .angle(roll_angle), .result(sc_roll)
    );
    e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch
    (
        .clk(clk), .angle(pitch_angle), .result(sc_pitch)
    );
    e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw
    (
        .clk(clk), .angle(yaw_angle), .result(sc_yaw)
    );

    e2q_merge #(.QUAT_WIDTH(QUAT_WIDTH)) u_merge
    (
        .clk(clk), .roll(sc_roll), .pitch(sc_pitch), .yaw(sc_yaw),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    // Track request valid along the pipeline
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    assign vld_next = {vld_reg[LAT-2:0], start};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    `E2Q_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `E2Q_ASSERT_NEXT(a_valid_shift, clk, rst_n, start, vld_reg[0])
    `E2Q_ASSERT_NEXT(a_done_follows, clk, rst_n, vld_reg[LAT-2], done)

endmodule
